### rtl/tea_pkg.sv
// ----------------------------------------------------------------------------
// tea_pkg
// Constants, types and state codes for the triangle edge adjacency builder.
// ----------------------------------------------------------------------------
package tea_pkg;

  localparam int TriMax    = 1024;
  localparam int VertMax   = 4096;
  localparam int EdgeSlots = 4096;

  localparam int TriW   = 10;
  localparam int VertW  = 12;
  localparam int TriAw  = $clog2(TriMax);
  localparam int VertAw = $clog2(VertMax);
  localparam int EdgeAw = $clog2(EdgeSlots);

  localparam int ClrDepth = (EdgeSlots > TriMax) ? EdgeSlots : TriMax;
  localparam int ClrAw    = $clog2(ClrDepth);

  localparam int EpochW = 8;
  localparam logic [EpochW-1:0] EpochMax = {EpochW{1'b1}};

  localparam logic [31:0] HashMul = 32'h9E3779B1;
  localparam logic [1:0]  MaxNbr  = 2'd3;

  typedef enum logic [1:0] {
    EDGE_AB,
    EDGE_BC,
    EDGE_CA
  } edge_num_e;

  typedef enum logic [1:0] {
    ST_NEW,
    ST_PAIRED,
    ST_REFUSED,
    ST_FULL
  } edge_status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_START,
    S_EDGE,
    S_READ,
    S_CHECK,
    S_PAIR,
    S_EMIT,
    S_WB
  } tea_state_e;

  typedef struct packed {
    logic              valid;
    logic [EpochW-1:0] epoch;
    logic [VertAw-1:0] lo;
    logic [VertAw-1:0] hi;
    logic [TriW-1:0]   owner;
  } edge_entry_t;

  typedef struct packed {
    logic [EpochW-1:0] epoch;
    logic [1:0]        cnt;
  } nbr_entry_t;

endpackage

### rtl/triangle_edge_adjacency.sv
// ----------------------------------------------------------------------------
// triangle_edge_adjacency
// Builds triangle adjacency from a stream of triangles using an edge hash
// table and a neighbor count table, both in synchronous memories.
// ----------------------------------------------------------------------------
// One triangle word is taken at a time and gives three result words, one per
// edge (ab, bc, ca). Each edge goes through hash, read, check (repeated for
// each extra probe of the edge table through its single read port), an
// optional neighbor count update and a hand-off of the word to the output
// register. After reset, and on every 256th triangle that starts a new mesh,
// the block sweeps both memories before it takes or finishes a triangle;
// other new meshes are started at once by advancing an epoch tag stored with
// every entry.
module triangle_edge_adjacency
  import tea_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             new_mesh_i,
  input  logic [TriW-1:0]  tri_id_i,
  input  logic [VertW-1:0] vert_a_i,
  input  logic [VertW-1:0] vert_b_i,
  input  logic [VertW-1:0] vert_c_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [1:0]       edge_number_o,
  output logic [1:0]       status_o,
  output logic [TriW-1:0]  partner_o,
  output logic [1:0]       own_slot_o,
  output logic [1:0]       partner_slot_o,
  output logic             last_o
);

  // Control state
  tea_state_e        state_q, state_d;
  logic [ClrAw-1:0]  clr_q, clr_d;
  logic              pend_q, pend_d;
  logic [EpochW-1:0] epoch_q, epoch_d;
  logic              out_valid_q, out_valid_d;

  // Item and edge payload
  logic [TriW-1:0]   tri_q, tri_d;
  logic [VertAw-1:0] va_q, va_d, vb_q, vb_d, vc_q, vc_d;
  edge_num_e         edge_k_q, edge_k_d;
  logic [VertAw-1:0] lo_q, lo_d, hi_q, hi_d;
  logic [EdgeAw-1:0] pos_q, pos_d;
  logic [EdgeAw:0]   probe_q, probe_d;
  logic [1:0]        own_cnt_q, own_cnt_d;

  edge_status_e      res_status_q, res_status_d;
  logic [TriW-1:0]   res_partner_q, res_partner_d;
  logic [1:0]        res_own_q, res_own_d, res_pslot_q, res_pslot_d;

  logic [1:0]        out_edge_q;
  edge_status_e      out_status_q;
  logic [TriW-1:0]   out_partner_q;
  logic [1:0]        out_own_q, out_pslot_q;
  logic              out_last_q;

  // Memories
  edge_entry_t       et_mem [EdgeSlots];
  edge_entry_t       et_rdata_q;
  logic              et_we;
  logic [EdgeAw-1:0] et_waddr;
  edge_entry_t       et_wdata;

  nbr_entry_t        nc_mem [TriMax];
  nbr_entry_t        nc_rdata_q;
  logic              nc_we;
  logic [TriAw-1:0]  nc_waddr, nc_raddr;
  nbr_entry_t        nc_wdata;

  // Datapath helpers
  logic              in_accept, out_load;
  logic [VertAw-1:0] edge_u, edge_v, key_lo, key_hi;
  logic [EdgeAw-1:0] hash_mul_lo, home;
  logic              et_live, et_match, probe_last;
  logic [EdgeAw:0]   probe_nxt;
  logic [TriAw-1:0]  ci, cj;
  logic [1:0]        nc_val, sj;
  logic              refuse;

  assign in_accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign out_load  = (state_q == S_EMIT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    unique case (edge_k_q)
      EDGE_AB: begin
        edge_u = va_q;
        edge_v = vb_q;
      end
      EDGE_BC: begin
        edge_u = vb_q;
        edge_v = vc_q;
      end
      EDGE_CA: begin
        edge_u = vc_q;
        edge_v = va_q;
      end
      default: begin
        edge_u = va_q;
        edge_v = vb_q;
      end
    endcase
  end

  assign key_lo = (edge_u < edge_v) ? edge_u : edge_v;
  assign key_hi = (edge_u < edge_v) ? edge_v : edge_u;

  // Only the low address bits of the multiplicative hash survive the modulo.
  assign hash_mul_lo = HashMul[EdgeAw-1:0];
  assign home = (EdgeAw'(key_lo) * hash_mul_lo) ^ EdgeAw'(key_hi);

  assign et_live    = et_rdata_q.valid && (et_rdata_q.epoch == epoch_q);
  assign et_match   = (et_rdata_q.lo == lo_q) && (et_rdata_q.hi == hi_q);
  assign probe_nxt  = probe_q + 1'b1;
  assign probe_last = (probe_nxt == (EdgeAw + 1)'(EdgeSlots));

  assign ci     = tri_q[TriAw-1:0];
  assign cj     = res_partner_q[TriAw-1:0];
  assign nc_val = (nc_rdata_q.epoch == epoch_q) ? nc_rdata_q.cnt : 2'd0;
  // The own count is held locally until the triangle is done.
  assign sj     = (cj == ci) ? own_cnt_q : nc_val;
  assign refuse = (own_cnt_q == MaxNbr) || (sj == MaxNbr);
  assign nc_raddr = (state_q == S_CHECK) ? et_rdata_q.owner[TriAw-1:0] : ci;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (clr_q == ClrAw'(ClrDepth - 1)) begin
          state_d = pend_q ? S_START : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          state_d = (new_mesh_i && epoch_q == EpochMax) ? S_CLEAR : S_START;
        end
      end
      S_START: state_d = S_EDGE;
      S_EDGE:  state_d = S_READ;
      S_READ:  state_d = S_CHECK;
      S_CHECK: begin
        if (!et_live) begin
          state_d = S_EMIT;
        end else if (et_match) begin
          state_d = S_PAIR;
        end else if (probe_last) begin
          state_d = S_EMIT;
        end else begin
          state_d = S_READ;
        end
      end
      S_PAIR: state_d = S_EMIT;
      S_EMIT: begin
        if (out_load) begin
          state_d = (edge_k_q == EDGE_CA) ? S_WB : S_EDGE;
        end
      end
      S_WB:    state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    clr_d         = clr_q;
    pend_d        = pend_q;
    epoch_d       = epoch_q;
    tri_d         = tri_q;
    va_d          = va_q;
    vb_d          = vb_q;
    vc_d          = vc_q;
    edge_k_d      = edge_k_q;
    lo_d          = lo_q;
    hi_d          = hi_q;
    pos_d         = pos_q;
    probe_d       = probe_q;
    own_cnt_d     = own_cnt_q;
    res_status_d  = res_status_q;
    res_partner_d = res_partner_q;
    res_own_d     = res_own_q;
    res_pslot_d   = res_pslot_q;

    et_we    = 1'b0;
    et_waddr = pos_q;
    et_wdata = '{valid: 1'b1, epoch: epoch_q, lo: lo_q, hi: hi_q, owner: tri_q};
    nc_we    = 1'b0;
    nc_waddr = ci;
    nc_wdata = '{epoch: epoch_q, cnt: own_cnt_q};

    unique case (state_q)
      S_CLEAR: begin
        et_we    = 1'b1;
        et_waddr = clr_q[EdgeAw-1:0];
        et_wdata = '0;
        nc_we    = 1'b1;
        nc_waddr = clr_q[TriAw-1:0];
        nc_wdata = '0;
        clr_d    = clr_q + 1'b1;
        if (clr_q == ClrAw'(ClrDepth - 1)) begin
          pend_d = 1'b0;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          tri_d    = tri_id_i;
          va_d     = vert_a_i[VertAw-1:0];
          vb_d     = vert_b_i[VertAw-1:0];
          vc_d     = vert_c_i[VertAw-1:0];
          edge_k_d = EDGE_AB;
          if (new_mesh_i) begin
            epoch_d = epoch_q + 1'b1;
            // The epoch tag wraps here, so stale entries must be swept out.
            if (epoch_q == EpochMax) begin
              pend_d = 1'b1;
              clr_d  = '0;
            end
          end
        end
      end
      S_START: begin
      end
      S_EDGE: begin
        if (edge_k_q == EDGE_AB) begin
          own_cnt_d = nc_val;
        end
        lo_d    = key_lo;
        hi_d    = key_hi;
        pos_d   = home;
        probe_d = '0;
      end
      S_READ: begin
      end
      S_CHECK: begin
        res_partner_d = '0;
        res_own_d     = '0;
        res_pslot_d   = '0;
        if (!et_live) begin
          et_we        = 1'b1;
          res_status_d = ST_NEW;
        end else if (et_match) begin
          res_partner_d = et_rdata_q.owner;
        end else if (probe_last) begin
          res_status_d = ST_FULL;
        end else begin
          probe_d = probe_nxt;
          pos_d   = pos_q + 1'b1;
        end
      end
      S_PAIR: begin
        if (refuse) begin
          res_status_d = ST_REFUSED;
        end else begin
          res_status_d = ST_PAIRED;
          res_own_d    = own_cnt_q;
          res_pslot_d  = sj;
          own_cnt_d    = own_cnt_q + 1'b1;
          if (cj != ci) begin
            nc_we    = 1'b1;
            nc_waddr = cj;
            nc_wdata = '{epoch: epoch_q, cnt: sj + 2'd1};
          end
        end
      end
      S_EMIT: begin
        if (out_load && edge_k_q != EDGE_CA) begin
          edge_k_d = edge_num_e'(edge_k_q + 2'd1);
        end
      end
      S_WB: begin
        nc_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      pend_q      <= 1'b0;
      epoch_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      pend_q      <= pend_d;
      epoch_q     <= epoch_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tri_q         <= tri_d;
    va_q          <= va_d;
    vb_q          <= vb_d;
    vc_q          <= vc_d;
    edge_k_q      <= edge_k_d;
    lo_q          <= lo_d;
    hi_q          <= hi_d;
    pos_q         <= pos_d;
    probe_q       <= probe_d;
    own_cnt_q     <= own_cnt_d;
    res_status_q  <= res_status_d;
    res_partner_q <= res_partner_d;
    res_own_q     <= res_own_d;
    res_pslot_q   <= res_pslot_d;
    if (out_load) begin
      out_edge_q    <= edge_k_q;
      out_status_q  <= res_status_q;
      out_partner_q <= res_partner_q;
      out_own_q     <= res_own_q;
      out_pslot_q   <= res_pslot_q;
      out_last_q    <= (edge_k_q == EDGE_CA);
    end
  end

  // Edge table: one write port, one registered read port at the probe address.
  always_ff @(posedge clk_i) begin
    if (et_we) begin
      et_mem[et_waddr] <= et_wdata;
    end
    et_rdata_q <= et_mem[pos_q];
  end

  // Neighbor count table.
  always_ff @(posedge clk_i) begin
    if (nc_we) begin
      nc_mem[nc_waddr] <= nc_wdata;
    end
    nc_rdata_q <= nc_mem[nc_raddr];
  end

  assign out_valid_o    = out_valid_q;
  assign edge_number_o  = out_edge_q;
  assign status_o       = out_status_q;
  assign partner_o      = out_partner_q;
  assign own_slot_o     = out_own_q;
  assign partner_slot_o = out_pslot_q;
  assign last_o         = out_last_q;

  // The probe loop must stop at a full table before it revisits a slot.
  a_probe_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHECK) |-> (probe_q < (EdgeAw + 1)'(EdgeSlots)))
    else $error("edge table probe count overran the table");

  // Handing off the third word must lead to the count write-back.
  a_last_to_wb : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && edge_k_q == EDGE_CA) |=> (state_q == S_WB))
    else $error("third result word not followed by count write-back");

  // No table is written while the block waits for a triangle.
  a_idle_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (!et_we && !nc_we))
    else $error("memory write while idle");

  // The epoch only moves when a triangle is taken.
  a_epoch_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |=> $stable(epoch_q))
    else $error("epoch changed during a triangle or a sweep");

endmodule
